// ===== hw/rtl/fixed_block_pool_allocator_defines.svh =====
// assertion macros used by the block pool allocator checker
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk and disabled in reset
`define FBPA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and disabled in reset
`define FBPA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fbpa_pkg.sv =====
// shared types and constants of the block pool allocator
package fbpa_pkg;

    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int LINK_W  = 6;
    localparam int CNT_W   = 7;
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 17;
    localparam int PROD_W  = SIZE_W + LINK_W;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 2;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INIT    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [REG_W-1:0] REG_BLOCK_COUNT  = 2'd0;
    localparam logic [REG_W-1:0] REG_BASE_ADDRESS = 2'd1;
    localparam logic [REG_W-1:0] REG_BLOCK_SIZE   = 2'd2;

    localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT  = 7'd64;
    localparam logic [ADDR_W-1:0] RST_BASE_ADDRESS = 32'd0;
    localparam logic [SIZE_W-1:0] RST_BLOCK_SIZE   = 17'd4;

    typedef struct packed {
        logic [CNT_W-1:0]  block_count;
        logic [ADDR_W-1:0] base_address;
        logic [SIZE_W-1:0] blk_bytes;
    } cfg_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LINK_W-1:0] granted_index;
        logic [ADDR_W-1:0] granted_address;
        logic [CNT_W-1:0]  free_blocks;
        logic [CNT_W-1:0]  used_blocks;
    } rsp_t;

endpackage

// ===== hw/rtl/fbpa_if.sv =====
// request and response channel interfaces of the block pool allocator
interface fbpa_in_if;
    logic                       valid;
    logic                       ready;
    logic [fbpa_pkg::ACT_W-1:0]  action;
    logic [fbpa_pkg::LINK_W-1:0] block_index;

    modport source (output valid, output action, output block_index, input ready);
    modport sink (input valid, input action, input block_index, output ready);
endinterface

interface fbpa_out_if;
    logic                        valid;
    logic                        ready;
    logic [fbpa_pkg::STAT_W-1:0] status;
    logic [fbpa_pkg::LINK_W-1:0] granted_index;
    logic [fbpa_pkg::ADDR_W-1:0] granted_address;
    logic [fbpa_pkg::CNT_W-1:0]  free_blocks;
    logic [fbpa_pkg::CNT_W-1:0]  used_blocks;

    modport source (output valid, output status, output granted_index,
                    output granted_address, output free_blocks, output used_blocks,
                    input ready);
    modport sink (input valid, input status, input granted_index,
                  input granted_address, input free_blocks, input used_blocks,
                  output ready);
endinterface

// ===== hw/rtl/fbpa_link_ram.sv =====
// free-list link memory, one write port and one registered read port
module fbpa_link_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [fbpa_pkg::LINK_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [fbpa_pkg::LINK_W-1:0] rd_data
);

    logic [fbpa_pkg::LINK_W-1:0] mem_reg [DEPTH];
    logic [fbpa_pkg::LINK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/fbpa_seq.sv =====
// request sequencer: head and free count, link memory access, init sweep, output register
module fbpa_seq #(
    parameter int NUM_BLOCKS = 64,
    parameter int AW         = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fbpa_pkg::cfg_t              cfg,
    fbpa_in_if.sink                     req,
    fbpa_out_if.source                  rsp,
    output logic                        mem_wr_en,
    output logic [AW-1:0]               mem_wr_addr,
    output logic [fbpa_pkg::LINK_W-1:0] mem_wr_data,
    output logic                        mem_rd_en,
    output logic [AW-1:0]               mem_rd_addr,
    input  logic [fbpa_pkg::LINK_W-1:0] mem_rd_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_INIT = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [fbpa_pkg::LINK_W-1:0]   head_reg, head_next;
    logic [fbpa_pkg::CNT_W-1:0]    free_reg, free_next;
    logic [fbpa_pkg::CNT_W-1:0]    sweep_reg, sweep_next;
    logic [fbpa_pkg::LINK_W-1:0]   gidx_reg, gidx_next;
    logic [fbpa_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic                          oob_reg, oob_next;
    fbpa_pkg::rsp_t                out_reg, out_next;
    fbpa_pkg::rsp_t                hold_reg, hold_next;
    logic                          out_valid_reg, out_valid_next;

    logic [fbpa_pkg::CNT_W-1:0]    eff_count;
    logic                          req_fire;
    logic                          slot_free;
    logic                          done;
    fbpa_pkg::rsp_t                res;
    logic [fbpa_pkg::STAT_W-1:0]   res_status;
    logic [fbpa_pkg::LINK_W-1:0]   res_gidx;
    logic [fbpa_pkg::ADDR_W-1:0]   res_gaddr;

    // block count clamped to at least two and at most the pool size
    always_comb
    begin
        if (cfg.block_count < fbpa_pkg::CNT_W'(2))
        begin
            eff_count = fbpa_pkg::CNT_W'(2);
        end
        else if (int'(cfg.block_count) > NUM_BLOCKS)
        begin
            eff_count = fbpa_pkg::CNT_W'(NUM_BLOCKS);
        end
        else
        begin
            eff_count = cfg.block_count;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        sweep_next     = sweep_reg;
        gidx_next      = gidx_reg;
        prod_next      = prod_reg;
        oob_next       = oob_reg;
        out_next       = out_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = '0;
        mem_wr_data    = '0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = '0;
        done           = 1'b0;
        res_status     = fbpa_pkg::ST_OK;
        res_gidx       = '0;
        res_gaddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.action)
                        fbpa_pkg::ACT_ALLOC:
                        begin
                            if (free_reg != '0)
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(head_reg);
                                gidx_next   = head_reg;
                                prod_next   = fbpa_pkg::PROD_W'(head_reg)
                                            * fbpa_pkg::PROD_W'(cfg.blk_bytes);
                                oob_next    = !(int'(head_reg) < NUM_BLOCKS);
                                state_next  = S_READ;
                            end
                            else
                            begin
                                done       = 1'b1;
                                res_status = fbpa_pkg::ST_EMPTY;
                            end
                        end
                        fbpa_pkg::ACT_RELEASE:
                        begin
                            done = 1'b1;
                            if (free_reg < eff_count)
                            begin
                                // an index past the memory moves the head but links nothing
                                mem_wr_en   = (int'(req.block_index) < NUM_BLOCKS);
                                mem_wr_addr = AW'(req.block_index);
                                mem_wr_data = head_reg;
                                head_next   = req.block_index;
                                free_next   = free_reg + fbpa_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                res_status = fbpa_pkg::ST_OVERFLOW;
                            end
                        end
                        fbpa_pkg::ACT_INIT:
                        begin
                            sweep_next = '0;
                            state_next = S_INIT;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // link of the popped block arrives from the memory this cycle
                head_next = oob_reg ? '0 : mem_rd_data;
                free_next = free_reg - fbpa_pkg::CNT_W'(1);
                done      = 1'b1;
                res_gidx  = gidx_reg;
                res_gaddr = cfg.base_address + fbpa_pkg::ADDR_W'(prod_reg);
            end
            S_INIT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(sweep_reg);
                sweep_next  = sweep_reg + fbpa_pkg::CNT_W'(1);
                if (sweep_reg == eff_count - fbpa_pkg::CNT_W'(1))
                begin
                    mem_wr_data = '0;
                    head_next   = '0;
                    free_next   = eff_count;
                    done        = 1'b1;
                end
                else
                begin
                    mem_wr_data = fbpa_pkg::LINK_W'(sweep_reg + fbpa_pkg::CNT_W'(1));
                end
            end
            S_HOLD:
            begin
                done = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_HOLD)
        begin
            res = hold_reg;
        end
        else
        begin
            res.status          = res_status;
            res.granted_index   = res_gidx;
            res.granted_address = res_gaddr;
            res.free_blocks     = free_next;
            res.used_blocks     = (eff_count > free_next) ? (eff_count - free_next) : '0;
        end

        // result goes straight to the output register when it is free, else parks
        if (done)
        begin
            if (slot_free)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                hold_next  = res;
                state_next = S_HOLD;
            end
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_reg <= sweep_next;
        gidx_reg  <= gidx_next;
        prod_reg  <= prod_next;
        oob_reg   <= oob_next;
        out_reg   <= out_next;
        hold_reg  <= hold_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.granted_index   = out_reg.granted_index;
    assign rsp.granted_address = out_reg.granted_address;
    assign rsp.free_blocks     = out_reg.free_blocks;
    assign rsp.used_blocks     = out_reg.used_blocks;

endmodule

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
// Fixed-size block pool allocator keeping its free blocks as a linked list in a link memory.
// Each request (allocate, release or init) gives one response through an output register,
// and a new request is taken while an earlier response still waits to be read. A release,
// an allocate that finds the pool empty or an unused action code is decided in the idle
// state. An allocate that pops a block then passes through a read state for the registered
// read of the link memory that fetches the next head. An init runs the sweep that writes
// one link entry per cycle up to the effective block count. After reset, allocate reports
// empty until the first init or release. The user must write configuration registers over
// the APB port only while no request is in flight; the block itself does not enforce it.
module fixed_block_pool_allocator #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    fbpa_in_if.sink                      req,
    fbpa_out_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fbpa_pkg::PADDR_W-1:0] paddr,
    input  logic [fbpa_pkg::PDATA_W-1:0] pwdata,
    output logic [fbpa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int LINK_AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    fbpa_pkg::cfg_t                cfg_reg, cfg_next;
    logic [fbpa_pkg::REG_W-1:0]    reg_sel;
    logic                          cfg_write;

    logic                          mem_wr_en;
    logic [LINK_AW-1:0]            mem_wr_addr;
    logic [fbpa_pkg::LINK_W-1:0]   mem_wr_data;
    logic                          mem_rd_en;
    logic [LINK_AW-1:0]            mem_rd_addr;
    logic [fbpa_pkg::LINK_W-1:0]   mem_rd_data;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[fbpa_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                fbpa_pkg::REG_BLOCK_COUNT:
                begin
                    cfg_next.block_count = pwdata[fbpa_pkg::CNT_W-1:0];
                end
                fbpa_pkg::REG_BASE_ADDRESS:
                begin
                    cfg_next.base_address = pwdata[fbpa_pkg::ADDR_W-1:0];
                end
                fbpa_pkg::REG_BLOCK_SIZE:
                begin
                    cfg_next.blk_bytes = pwdata[fbpa_pkg::SIZE_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            fbpa_pkg::REG_BLOCK_COUNT:
            begin
                prdata = fbpa_pkg::PDATA_W'(cfg_reg.block_count);
            end
            fbpa_pkg::REG_BASE_ADDRESS:
            begin
                prdata = fbpa_pkg::PDATA_W'(cfg_reg.base_address);
            end
            fbpa_pkg::REG_BLOCK_SIZE:
            begin
                prdata = fbpa_pkg::PDATA_W'(cfg_reg.blk_bytes);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_count  <= fbpa_pkg::RST_BLOCK_COUNT;
            cfg_reg.base_address <= fbpa_pkg::RST_BASE_ADDRESS;
            cfg_reg.blk_bytes    <= fbpa_pkg::RST_BLOCK_SIZE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fbpa_seq #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .AW         (LINK_AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    fbpa_link_ram #(
        .DEPTH (NUM_BLOCKS),
        .AW    (LINK_AW)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== hw/rtl/fbpa_checker.sv =====
// port-level assertions of the block pool allocator and their bind
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_checker #(
    parameter int NUM_BLOCKS = 64
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [fbpa_pkg::STAT_W-1:0] rsp_status,
    input logic [fbpa_pkg::LINK_W-1:0] rsp_granted_index,
    input logic [fbpa_pkg::ADDR_W-1:0] rsp_granted_address,
    input logic [fbpa_pkg::CNT_W-1:0]  rsp_free_blocks,
    input logic [fbpa_pkg::CNT_W-1:0]  rsp_used_blocks
);

    // a stalled response keeps its status, granted address and free count
    `FBPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_granted_address) && $stable(rsp_free_blocks), "stalled response changed")

    `FBPA_ASSERT_IMPL(a_empty_grant, rsp_valid && (rsp_status == fbpa_pkg::ST_EMPTY), (rsp_free_blocks == '0) && (rsp_granted_index == '0) && (rsp_granted_address == '0), "empty response with free blocks or a grant")

    `FBPA_ASSERT_IMPL(a_overflow_used, rsp_valid && (rsp_status == fbpa_pkg::ST_OVERFLOW), (rsp_used_blocks == '0) && (rsp_granted_index == '0), "overflow response with blocks in use")

    // free plus used never exceeds the pool
    `FBPA_ASSERT_IMPL(a_count_bound, rsp_valid, (int'(rsp_free_blocks) + int'(rsp_used_blocks)) <= NUM_BLOCKS, "free plus used counts exceed the pool")

endmodule

bind fixed_block_pool_allocator fbpa_checker #(
    .NUM_BLOCKS (NUM_BLOCKS)
) u_fbpa_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_granted_index   (rsp.granted_index),
    .rsp_granted_address (rsp.granted_address),
    .rsp_free_blocks     (rsp.free_blocks),
    .rsp_used_blocks     (rsp.used_blocks)
);

// ===== dv/tb_fixed_block_pool_allocator.sv =====
// testbench for the fixed block pool allocator: directed table, random phases, self-checking
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator;

    localparam int POOL_BLOCKS     = 64;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_REQUESTS  = 152;
    localparam int PRESSURE_PHASE  = 4;
    localparam int HOLD_CYCLES     = 300;
    localparam int INIT_SETTLE     = POOL_BLOCKS + 16;
    localparam int LIMIT_NS        = 10_000_000;

    // code the block treats as a no-op
    localparam logic [fbpa_pkg::ACT_W-1:0] ACT_NONE = 2'd3;

    typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [1:0]        code;
        logic [31:0]       value;
        bit                fixed;
        fbpa_pkg::rsp_t    want;
    } stim_row_t;

    localparam int N_DIRECTED = 29;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_REQ, fbpa_pkg::ACT_ALLOC, 32'd0, 1'b1,
          '{fbpa_pkg::ST_EMPTY, 6'd0, 32'd0, 7'd0, 7'd64}},
        '{ROW_REQ, ACT_NONE, 32'd63, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd0, 32'd0, 7'd0, 7'd64}},
        '{ROW_REQ, fbpa_pkg::ACT_INIT, 32'd0, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd0, 32'd0, 7'd64, 7'd0}},
        '{ROW_REQ, fbpa_pkg::ACT_RELEASE, 32'd0, 1'b1,
          '{fbpa_pkg::ST_OVERFLOW, 6'd0, 32'd0, 7'd64, 7'd0}},
        '{ROW_REQ, fbpa_pkg::ACT_ALLOC, 32'd0, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd0, 32'd0, 7'd63, 7'd1}},
        '{ROW_REQ, fbpa_pkg::ACT_ALLOC, 32'd0, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd1, 32'd4, 7'd62, 7'd2}},
        '{ROW_CFG, fbpa_pkg::REG_BASE_ADDRESS, 32'hFFFF_FFF0, 1'b0, '0},
        '{ROW_CFG, fbpa_pkg::REG_BLOCK_SIZE,   32'h0001_0000, 1'b0, '0},
        // count dropped under the free count, used count saturates
        '{ROW_CFG, fbpa_pkg::REG_BLOCK_COUNT,  32'd2,         1'b0, '0},
        '{ROW_REQ, fbpa_pkg::ACT_ALLOC, 32'd0, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd2, 32'h0001_FFF0, 7'd61, 7'd0}},
        '{ROW_REQ, fbpa_pkg::ACT_RELEASE, 32'd63, 1'b1,
          '{fbpa_pkg::ST_OVERFLOW, 6'd0, 32'd0, 7'd61, 7'd0}},
        // zero count is taken as two
        '{ROW_CFG, fbpa_pkg::REG_BLOCK_COUNT,  32'd0,         1'b0, '0},
        '{ROW_REQ, fbpa_pkg::ACT_INIT, 32'd0, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd0, 32'd0, 7'd2, 7'd0}},
        '{ROW_REQ, fbpa_pkg::ACT_ALLOC, 32'd0, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd0, 32'hFFFF_FFF0, 7'd1, 7'd1}},
        '{ROW_REQ, fbpa_pkg::ACT_ALLOC, 32'd0, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd1, 32'h0000_FFF0, 7'd0, 7'd2}},
        '{ROW_REQ, fbpa_pkg::ACT_ALLOC, 32'd0, 1'b1,
          '{fbpa_pkg::ST_EMPTY, 6'd0, 32'd0, 7'd0, 7'd2}},
        // out of range index and double release are not caught
        '{ROW_REQ, fbpa_pkg::ACT_RELEASE, 32'd63, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd0, 32'd0, 7'd1, 7'd1}},
        '{ROW_REQ, fbpa_pkg::ACT_RELEASE, 32'd63, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd0, 32'd0, 7'd2, 7'd0}},
        '{ROW_REQ, fbpa_pkg::ACT_RELEASE, 32'd0, 1'b1,
          '{fbpa_pkg::ST_OVERFLOW, 6'd0, 32'd0, 7'd2, 7'd0}},
        '{ROW_REQ, fbpa_pkg::ACT_ALLOC, 32'd0, 1'b0, '0},
        '{ROW_REQ, fbpa_pkg::ACT_ALLOC, 32'd0, 1'b0, '0},
        // count above the pool is clamped
        '{ROW_CFG, fbpa_pkg::REG_BLOCK_COUNT,  32'd127,       1'b0, '0},
        '{ROW_CFG, fbpa_pkg::REG_BASE_ADDRESS, 32'd0,         1'b0, '0},
        '{ROW_CFG, fbpa_pkg::REG_BLOCK_SIZE,   32'd4,         1'b0, '0},
        '{ROW_REQ, fbpa_pkg::ACT_INIT, 32'd0, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd0, 32'd0, 7'd64, 7'd0}},
        '{ROW_REQ, ACT_NONE, 32'd0, 1'b1,
          '{fbpa_pkg::ST_OK, 6'd0, 32'd0, 7'd64, 7'd0}},
        '{ROW_REQ, fbpa_pkg::ACT_ALLOC, 32'd0, 1'b0, '0},
        '{ROW_REQ, fbpa_pkg::ACT_RELEASE, 32'd42, 1'b0, '0},
        '{ROW_REQ, fbpa_pkg::ACT_ALLOC, 32'd0, 1'b0, '0}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [fbpa_pkg::PADDR_W-1:0]  paddr;
    logic [fbpa_pkg::PDATA_W-1:0]  pwdata;
    logic [fbpa_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    fbpa_in_if  req_if ();
    fbpa_out_if rsp_if ();

    fixed_block_pool_allocator #(
        .NUM_BLOCKS (POOL_BLOCKS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the configuration and of the free list
    logic [fbpa_pkg::CNT_W-1:0]  cfg_count = fbpa_pkg::RST_BLOCK_COUNT;
    logic [fbpa_pkg::ADDR_W-1:0] cfg_base  = fbpa_pkg::RST_BASE_ADDRESS;
    logic [fbpa_pkg::SIZE_W-1:0] cfg_size  = fbpa_pkg::RST_BLOCK_SIZE;

    logic [fbpa_pkg::LINK_W-1:0] link_shadow [POOL_BLOCKS];
    logic [fbpa_pkg::LINK_W-1:0] head_shadow = '0;
    int                          free_shadow = 0;

    fbpa_pkg::rsp_t              predicted_rsp_q [$];
    logic [fbpa_pkg::LINK_W-1:0] blocks_in_use [$];
    int                          mismatch_count = 0;
    bit                          req_idle_on = 1'b1;
    bit                          rsp_idle_on = 1'b1;
    bit                          hold_request = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int eff_pool_count();
        int c;
        c = int'(cfg_count);
        if (c < 2)
            c = 2;
        if (c > POOL_BLOCKS)
            c = POOL_BLOCKS;
        return c;
    endfunction

    // advances the shadow pool by one request and returns the response it gives
    function automatic fbpa_pkg::rsp_t pool_step(input logic [fbpa_pkg::ACT_W-1:0] act,
                                                 input logic [fbpa_pkg::LINK_W-1:0] idx);
        fbpa_pkg::rsp_t r;
        int             cnt;
        r   = '0;
        cnt = eff_pool_count();
        case (act)
            fbpa_pkg::ACT_INIT:
            begin
                for (int i = 0; i + 1 < cnt; i++)
                    link_shadow[i] = fbpa_pkg::LINK_W'(i + 1);
                link_shadow[cnt - 1] = '0;
                head_shadow = '0;
                free_shadow = cnt;
            end
            fbpa_pkg::ACT_ALLOC:
            begin
                if (free_shadow > 0)
                begin
                    r.granted_index   = head_shadow;
                    r.granted_address = cfg_base + fbpa_pkg::ADDR_W'(head_shadow)
                                      * fbpa_pkg::ADDR_W'(cfg_size);
                    head_shadow       = link_shadow[head_shadow];
                    free_shadow--;
                end
                else
                    r.status = fbpa_pkg::ST_EMPTY;
            end
            fbpa_pkg::ACT_RELEASE:
            begin
                if (free_shadow < cnt)
                begin
                    link_shadow[idx] = head_shadow;
                    head_shadow      = idx;
                    free_shadow++;
                end
                else
                    r.status = fbpa_pkg::ST_OVERFLOW;
            end
            default: ;
        endcase
        r.free_blocks = fbpa_pkg::CNT_W'(free_shadow);
        r.used_blocks = (cnt > free_shadow) ? fbpa_pkg::CNT_W'(cnt - free_shadow) : '0;
        return r;
    endfunction

    task automatic write_reg(input logic [fbpa_pkg::REG_W-1:0] sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fbpa_pkg::PADDR_W'({sel, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            fbpa_pkg::REG_BLOCK_COUNT:  cfg_count = value[fbpa_pkg::CNT_W-1:0];
            fbpa_pkg::REG_BASE_ADDRESS: cfg_base  = value[fbpa_pkg::ADDR_W-1:0];
            fbpa_pkg::REG_BLOCK_SIZE:   cfg_size  = value[fbpa_pkg::SIZE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // optional sender gap, then one request held until the block takes it
    task automatic issue_request(input logic [fbpa_pkg::ACT_W-1:0] act,
                                 input logic [fbpa_pkg::LINK_W-1:0] idx,
                                 input bit use_fixed, input fbpa_pkg::rsp_t fixed_rsp,
                                 output fbpa_pkg::rsp_t outcome);
        if (req_idle_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.action      <= act;
        req_if.block_index <= idx;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        outcome = pool_step(act, idx);
        predicted_rsp_q.push_back(use_fixed ? fixed_rsp : outcome);
    endtask

    task automatic drain_responses(input int settle);
        req_if.valid <= 1'b0;
        while (predicted_rsp_q.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // response side: random stalls, one long hold-off on demand, field checks
    initial
    begin
        fbpa_pkg::rsp_t seen;
        fbpa_pkg::rsp_t want;
        int             stall_left;
        int             hold_left;
        stall_left = 0;
        hold_left  = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            begin
                seen = '{rsp_if.status, rsp_if.granted_index, rsp_if.granted_address,
                         rsp_if.free_blocks, rsp_if.used_blocks};
                if (predicted_rsp_q.size() == 0)
                begin
                    $error("response with no request pending: %p", seen);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_rsp_q.pop_front();
                    if (seen.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, seen.status);
                        mismatch_count++;
                    end
                    if (seen.granted_index !== want.granted_index)
                    begin
                        $error("granted_index: expected %0d, got %0d",
                               want.granted_index, seen.granted_index);
                        mismatch_count++;
                    end
                    if (seen.granted_address !== want.granted_address)
                    begin
                        $error("granted_address: expected %08h, got %08h",
                               want.granted_address, seen.granted_address);
                        mismatch_count++;
                    end
                    if (seen.free_blocks !== want.free_blocks)
                    begin
                        $error("free_blocks: expected %0d, got %0d",
                               want.free_blocks, seen.free_blocks);
                        mismatch_count++;
                    end
                    if (seen.used_blocks !== want.used_blocks)
                    begin
                        $error("used_blocks: expected %0d, got %0d",
                               want.used_blocks, seen.used_blocks);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (rsp_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    initial
    begin
        fbpa_pkg::rsp_t              outcome;
        logic [fbpa_pkg::ACT_W-1:0]  act;
        logic [fbpa_pkg::LINK_W-1:0] idx;
        logic [31:0]                 count_v;
        logic [31:0]                 base_v;
        logic [31:0]                 size_v;
        bit                          filling;
        int                          roll;
        int                          pick;

        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_if.valid       <= 1'b0;
        req_if.action      <= fbpa_pkg::ACT_ALLOC;
        req_if.block_index <= '0;
        filling             = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                drain_responses(4);
                write_reg(directed_rows[r].code, directed_rows[r].value);
            end
            else
                issue_request(directed_rows[r].code,
                              directed_rows[r].value[fbpa_pkg::LINK_W-1:0],
                              directed_rows[r].fixed, directed_rows[r].want, outcome);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_responses(4);
            if (ph == 0)
            begin
                count_v = 32'd2;
                base_v  = 32'hFFFF_FFFF;
                size_v  = 32'h0001_FFFF;
            end
            else if (ph == 1)
            begin
                count_v = 32'd64;
                base_v  = 32'd0;
                size_v  = 32'd65536;
            end
            else if (ph == 2)
            begin
                count_v = 32'd1;
                base_v  = $urandom();
                size_v  = 32'd0;
            end
            else
            begin
                count_v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127)
                                                      : $urandom_range(2, 64);
                base_v  = $urandom();
                size_v  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17'h1FFFF)
                                                      : 4 * $urandom_range(1, 16384);
            end
            write_reg(fbpa_pkg::REG_BLOCK_COUNT, count_v);
            write_reg(fbpa_pkg::REG_BASE_ADDRESS, base_v);
            write_reg(fbpa_pkg::REG_BLOCK_SIZE, size_v);

            req_idle_on = (ph < RANDOM_PHASES - 2) && (ph % 3 != 2) && (ph != PRESSURE_PHASE);
            rsp_idle_on = (ph < RANDOM_PHASES - 2) && (ph % 3 != 2);
            if (ph == PRESSURE_PHASE)
                hold_request = 1'b1;

            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                roll = $urandom_range(0, 99);
                idx  = fbpa_pkg::LINK_W'($urandom_range(0, 63));
                if ((n == 0 && (ph == 0 || $urandom_range(0, 3) != 0)) || roll < 1)
                    act = fbpa_pkg::ACT_INIT;
                else if (roll < 3)
                    act = ACT_NONE;
                else if ((roll < 83) == filling)
                    act = fbpa_pkg::ACT_RELEASE;
                else
                    act = fbpa_pkg::ACT_ALLOC;

                // mostly hand back blocks that are really out, now and then a stray index
                if (act == fbpa_pkg::ACT_RELEASE && blocks_in_use.size() != 0
                    && $urandom_range(0, 9) != 0)
                begin
                    pick = $urandom_range(0, blocks_in_use.size() - 1);
                    idx  = blocks_in_use[pick];
                    blocks_in_use.delete(pick);
                end

                issue_request(act, idx, 1'b0, '0, outcome);

                if (act == fbpa_pkg::ACT_INIT)
                    blocks_in_use.delete();
                else if (act == fbpa_pkg::ACT_ALLOC && outcome.status == fbpa_pkg::ST_OK)
                    blocks_in_use.push_back(outcome.granted_index);

                if (outcome.status == fbpa_pkg::ST_EMPTY || outcome.free_blocks == 0)
                    filling = 1'b1;
                else if (outcome.status == fbpa_pkg::ST_OVERFLOW
                         || int'(outcome.free_blocks) >= eff_pool_count())
                    filling = 1'b0;
            end
        end

        drain_responses(INIT_SETTLE);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_if.sv
hw/rtl/fbpa_link_ram.sv
hw/rtl/fbpa_seq.sv
hw/rtl/fixed_block_pool_allocator.sv
hw/rtl/fbpa_checker.sv
dv/tb_fixed_block_pool_allocator.sv
